/* rtl/multi_channel_button_debouncer_defines.svh */
// Assertion macros shared by the debouncer RTL.
// Included by the lane, merge and top-level files; no other dependencies.
`ifndef MULTI_CHANNEL_BUTTON_DEBOUNCER_DEFINES_SVH
`define MULTI_CHANNEL_BUTTON_DEBOUNCER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define MCBD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");
// Next-cycle implication, disabled while reset is asserted.
`define MCBD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");
`else
`define MCBD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define MCBD_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* rtl/mcbd_pkg.sv */
// Shared types and constants for the multi-channel button debouncer.
// Used by mcbd_lane, mcbd_merge and the top level; depends on nothing.
package mcbd_pkg;

  // Fixed field widths.
  localparam int unsigned LANES_MAX    = 16;
  localparam int unsigned CH_W         = 4;
  localparam int unsigned CNT_W        = 8;
  localparam int unsigned THR_WORD_W   = 64;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CHANNELS_DEF = 16;

  // Counter constants.
  localparam logic [CNT_W-1:0] THR_MIN     = 8'd3;
  localparam logic [CNT_W-1:0] RELOAD_HIGH = 8'd3;
  localparam logic [CNT_W-1:0] RELOAD_LOW  = 8'd1;
  localparam logic [THR_WORD_W-1:0] THR_RESET = 64'h0505_0505_0505_0505;

  // Input action codes.
  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_ENABLE = 2'd1,
    ACT_READ   = 2'd2
  } action_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_LEVEL = 2'd0,
    CFG_THR_LOW      = 2'd1,
    CFG_THR_HIGH     = 2'd2
  } cfg_idx_e;

  // Per-lane control for one accepted beat.
  typedef struct packed {
    logic tick;
    logic pressed;
    logic enable_hit;
    logic disable_hit;
  } lane_ctrl_t;

  // Per-lane result for one accepted beat.
  typedef struct packed {
    logic status;
    logic rise;
    logic fall;
    logic clr;
  } lane_res_t;

endpackage

/* rtl/mcbd_lane.sv */
// One debounce lane: counter, debounced status, previous status, disable bit.
// Depends on mcbd_pkg and the debouncer assertion macros.
`include "multi_channel_button_debouncer_defines.svh"

module mcbd_lane (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mcbd_pkg::lane_ctrl_t           ctrl_i,
  input  logic [mcbd_pkg::CNT_W-1:0]     thr_i,
  output mcbd_pkg::lane_res_t            res_o
);
  import mcbd_pkg::*;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             status_q, status_d;
  logic             prev_q, prev_d;
  logic             dis_q, dis_d;
  logic [CNT_W-1:0] thr_eff;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] cnt_dec;

  // Threshold floor and counter arithmetic.
  assign thr_eff = (thr_i < THR_MIN) ? THR_MIN : thr_i;
  assign cnt_inc = cnt_q + CNT_W'(1);
  assign cnt_dec = cnt_q - CNT_W'(1);

  // Next state for one beat. A disabled lane always counts as released.
  always_comb begin
    cnt_d    = cnt_q;
    status_d = status_q;
    dis_d    = dis_q;
    if (ctrl_i.tick) begin
      if (ctrl_i.pressed && !dis_q) begin
        if (cnt_inc >= thr_eff) begin
          cnt_d    = RELOAD_HIGH;
          status_d = 1'b1;
        end else begin
          cnt_d = cnt_inc;
        end
      end else begin
        if (cnt_dec == '0) begin
          cnt_d    = RELOAD_LOW;
          status_d = 1'b0;
        end else begin
          cnt_d = cnt_dec;
        end
      end
    end
    if (ctrl_i.enable_hit) begin
      dis_d = 1'b0;
      cnt_d = RELOAD_LOW;
    end
    if (ctrl_i.disable_hit) begin
      dis_d    = 1'b1;
      status_d = 1'b0;
    end
    prev_d = ctrl_i.tick ? status_d : prev_q;
  end

  // Edge detection is only reported on ticks.
  always_comb begin
    res_o.status = status_d;
    res_o.rise   = ctrl_i.tick & status_d & ~prev_q;
    res_o.fall   = ctrl_i.tick & ~status_d & prev_q;
    res_o.clr    = ctrl_i.disable_hit;
  end

  // Lane state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= RELOAD_LOW;
      status_q <= 1'b0;
      prev_q   <= 1'b0;
      dis_q    <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      status_q <= status_d;
      prev_q   <= prev_d;
      dis_q    <= dis_d;
    end
  end

  // The counter reloads before it can reach the all-ones value or wrap to zero.
  `MCBD_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, 1'b1, (cnt_q != '0) && (cnt_q != '1))
  // A disabled lane never shows a pressed status.
  `MCBD_ASSERT_IMP(a_dis_status, clk_i, rst_ni, dis_q, !status_q)

endmodule

/* rtl/mcbd_merge.sv */
// Merge stage: combines lane results into event flags and the output beat.
// Depends on mcbd_pkg and the debouncer assertion macros.
`include "multi_channel_button_debouncer_defines.svh"

module mcbd_merge (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              step_i,
  input  logic [mcbd_pkg::LANES_MAX-1:0]    status_v_i,
  input  logic [mcbd_pkg::LANES_MAX-1:0]    rise_v_i,
  input  logic [mcbd_pkg::LANES_MAX-1:0]    fall_v_i,
  input  logic [mcbd_pkg::LANES_MAX-1:0]    clr_v_i,
  input  logic [mcbd_pkg::LANES_MAX-1:0]    read_v_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [mcbd_pkg::LANES_MAX-1:0]    status_bits_o,
  output logic [mcbd_pkg::LANES_MAX-1:0]    event_bits_o,
  output logic                              event_read_o
);
  import mcbd_pkg::*;

  logic [LANES_MAX-1:0] flags_q, flags_d;
  logic [LANES_MAX-1:0] step_flags;
  logic                 out_valid_q, out_valid_d;
  logic [LANES_MAX-1:0] status_bits_q;
  logic [LANES_MAX-1:0] event_bits_q;
  logic                 event_read_q;

  // Event flags after the step, then the read-and-clear.
  always_comb begin
    step_flags = flags_q;
    if (step_i) begin
      step_flags = (flags_q | rise_v_i) & ~fall_v_i & ~clr_v_i;
    end
    flags_d     = step_i ? (step_flags & ~read_v_i) : flags_q;
    out_valid_d = step_i | (out_valid_q & ~out_ready_i);
  end

  // Flag state and output beat register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      flags_q     <= flags_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload of the output beat; loaded on every accepted input beat.
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      status_bits_q <= status_v_i;
      event_bits_q  <= step_flags;
      event_read_q  <= |(step_flags & read_v_i);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_bits_o = status_bits_q;
  assign event_bits_o  = event_bits_q;
  assign event_read_o  = event_read_q;

  // A latched event always belongs to a channel that is pressed.
  `MCBD_ASSERT_IMP(a_evt_subset, clk_i, rst_ni, out_valid_q, (event_bits_q & ~status_bits_q) == '0)
  // A read can only return a flag that was shown in the same beat.
  `MCBD_ASSERT_IMP(a_read_flag, clk_i, rst_ni, out_valid_q && event_read_q, event_bits_q != '0)
  // A read clears the addressed flag.
  `MCBD_ASSERT_NXT(a_read_clr, clk_i, rst_ni, step_i && (read_v_i != '0), (flags_q & $past(read_v_i)) == '0)

endmodule

/* rtl/multi_channel_button_debouncer.sv */
// Top level of the multi-channel button debouncer: config registers, lanes, merge.
// Depends on mcbd_pkg, mcbd_lane, mcbd_merge and the assertion macros.
//
//   Channel   Direction  Handshake                  Payload
//   in        input      in_valid_i / in_ready_o    action_i, pin_levels_i, channel_i, enable_i
//   out       output     out_valid_o / out_ready_i  status_bits_o, event_bits_o, event_read_o
//   cfg       input      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// Every input beat yields one output beat in the cycle after it is accepted.
// All lanes update in the same cycle, so one beat can be taken per cycle;
// the single output register sets the rate to one beat per cycle while
// the output side keeps up. A stalled output beat holds the input only if
// the output register is full and not being taken. After reset all counters
// are 1, all channels enabled, thresholds 5, and the block is ready at once.
`include "multi_channel_button_debouncer_defines.svh"

module multi_channel_button_debouncer #(
  parameter int unsigned CHANNELS = mcbd_pkg::CHANNELS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          action_i,
  input  logic [mcbd_pkg::LANES_MAX-1:0]      pin_levels_i,
  input  logic [mcbd_pkg::CH_W-1:0]           channel_i,
  input  logic                                enable_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [mcbd_pkg::LANES_MAX-1:0]      status_bits_o,
  output logic [mcbd_pkg::LANES_MAX-1:0]      event_bits_o,
  output logic                                event_read_o,
  input  logic                                cfg_we_i,
  input  logic [mcbd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mcbd_pkg::THR_WORD_W-1:0]     cfg_data_i
);
  import mcbd_pkg::*;

  logic                    level_q;
  logic [THR_WORD_W-1:0]   thr_lo_q;
  logic [THR_WORD_W-1:0]   thr_hi_q;
  logic [2*THR_WORD_W-1:0] thr_all;
  logic                    step;
  logic                    is_tick, is_en, is_rd;
  logic                    ch_ok;
  logic [LANES_MAX-1:0]    status_v, rise_v, fall_v, clr_v, read_v;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q  <= 1'b0;
      thr_lo_q <= THR_RESET;
      thr_hi_q <= THR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ACTIVE_LEVEL: level_q  <= cfg_data_i[0];
        CFG_THR_LOW:      thr_lo_q <= cfg_data_i;
        CFG_THR_HIGH:     thr_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign thr_all = {thr_hi_q, thr_lo_q};

  // Input handshake: take a beat whenever the output register frees up.
  assign in_ready_o = !out_valid_o || out_ready_i;
  assign step       = in_valid_i && in_ready_o;

  // Action decode.
  always_comb begin
    is_tick = 1'b0;
    is_en   = 1'b0;
    is_rd   = 1'b0;
    case (action_e'(action_i))
      ACT_TICK:   is_tick = step;
      ACT_ENABLE: is_en   = step;
      ACT_READ:   is_rd   = step;
      default: ;
    endcase
  end

  assign ch_ok = ({1'b0, channel_i} < (CH_W + 1)'(CHANNELS));

  // Lanes; those beyond CHANNELS report zero.
  for (genvar c = 0; c < LANES_MAX; c++) begin : g_lane
    if (c < CHANNELS) begin : g_on
      lane_ctrl_t ctrl;
      lane_res_t  res;
      logic       sel;

      assign sel              = ch_ok && (channel_i == CH_W'(c));
      assign ctrl.tick        = is_tick;
      assign ctrl.pressed     = (pin_levels_i[c] == level_q);
      assign ctrl.enable_hit  = is_en && sel && enable_i;
      assign ctrl.disable_hit = is_en && sel && !enable_i;

      mcbd_lane u_lane (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (ctrl),
        .thr_i  (thr_all[c*CNT_W +: CNT_W]),
        .res_o  (res)
      );

      assign status_v[c] = res.status;
      assign rise_v[c]   = res.rise;
      assign fall_v[c]   = res.fall;
      assign clr_v[c]    = res.clr;
      assign read_v[c]   = is_rd && sel;
    end else begin : g_off
      assign status_v[c] = 1'b0;
      assign rise_v[c]   = 1'b0;
      assign fall_v[c]   = 1'b0;
      assign clr_v[c]    = 1'b0;
      assign read_v[c]   = 1'b0;
    end
  end

  // Merge lane results into the output beat.
  mcbd_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .status_v_i    (status_v),
    .rise_v_i      (rise_v),
    .fall_v_i      (fall_v),
    .clr_v_i       (clr_v),
    .read_v_i      (read_v),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .status_bits_o (status_bits_o),
    .event_bits_o  (event_bits_o),
    .event_read_o  (event_read_o)
  );

  // Every accepted beat produces an output beat in the next cycle.
  `MCBD_ASSERT_NXT(a_step_out, clk_i, rst_ni, step, out_valid_o)
  // At most one lane is addressed by an enable or read beat.
  `MCBD_ASSERT_IMP(a_one_sel, clk_i, rst_ni, 1'b1, $onehot0(read_v | clr_v))

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the multi-channel button debouncer.
// Depends on mcbd_pkg and the multi_channel_button_debouncer RTL only.
module tb;
  import mcbd_pkg::*;

  // Action code that the package leaves unnamed; the block must ignore it.
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int unsigned LANES = 16;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] pins;
    logic [3:0]  chan;
    logic        en;
  } button_beat_t;

  typedef struct packed {
    logic [15:0] status;
    logic [15:0] events;
    logic        rd;
  } button_report_t;

  // One directed step: the beat, and a typed-in report where it is obvious.
  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] pins;
    logic [3:0]  chan;
    logic        en;
    logic        fixed;
    logic [15:0] status;
    logic [15:0] events;
    logic        rd;
  } dir_row_t;

  // One random phase: register settings, beat count and how often the held
  // button pattern is redrawn (large values keep buttons held for long).
  typedef struct packed {
    logic        lvl;
    logic [63:0] lo;
    logic [63:0] hi;
    int          beats;
    int          churn;
  } phase_t;

  localparam int NUM_ROWS = 23;
  localparam dir_row_t DIR_ROWS [NUM_ROWS] = '{
    '{ACT_READ,   16'h0000, 4'd0,  1'b0, 1'b1, 16'h0000, 16'h0000, 1'b0},
    '{ACT_UNUSED, 16'hFFFF, 4'd15, 1'b1, 1'b1, 16'h0000, 16'h0000, 1'b0},
    '{ACT_TICK,   16'h0000, 4'd0,  1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{ACT_TICK,   16'h0000, 4'd5,  1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{ACT_TICK,   16'h0000, 4'd9,  1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{ACT_TICK,   16'h0000, 4'd0,  1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0},
    '{ACT_READ,   16'h1234, 4'd15, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1},
    '{ACT_READ,   16'h0000, 4'd15, 1'b0, 1'b1, 16'hFFFF, 16'h7FFF, 1'b0},
    '{ACT_ENABLE, 16'hFFFF, 4'd3,  1'b0, 1'b1, 16'hFFF7, 16'h7FF7, 1'b0},
    '{ACT_TICK,   16'h0000, 4'd0,  1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{ACT_ENABLE, 16'h0000, 4'd3,  1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{ACT_TICK,   16'hFFFF, 4'd0,  1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{ACT_TICK,   16'hFFFF, 4'd0,  1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{ACT_TICK,   16'hFFFF, 4'd0,  1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{ACT_TICK,   16'hAAAA, 4'd0,  1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{ACT_TICK,   16'h5555, 4'd0,  1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{ACT_TICK,   16'h0000, 4'd0,  1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{ACT_READ,   16'h0000, 4'd0,  1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{ACT_ENABLE, 16'hFFFF, 4'd0,  1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{ACT_ENABLE, 16'h0000, 4'd0,  1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{ACT_UNUSED, 16'h0000, 4'd0,  1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{ACT_TICK,   16'hFFFF, 4'd8,  1'b1, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{ACT_READ,   16'h0F0F, 4'd8,  1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0}
  };

  localparam int NUM_PHASES = 6;
  localparam phase_t PHASES [NUM_PHASES] = '{
    '{1'b0, THR_RESET,               THR_RESET,               300, 40},
    '{1'b1, 64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 500, 600},
    '{1'b0, 64'h0102_0304_0506_0708, 64'h0203_0403_0201_0006, 300, 30},
    '{1'b1, 64'h0A03_0F07_0C02_0409, 64'h0605_0403_0706_0504, 300, 60},
    '{1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000, 200, 600},
    '{1'b1, THR_RESET,               THR_RESET,               200, 40}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  action_i;
  logic [15:0] pin_levels_i;
  logic [3:0]  channel_i;
  logic        enable_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] status_bits_o;
  logic [15:0] event_bits_o;
  logic        event_read_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [63:0] cfg_data_i;

  // Typed-in report that travels with the current input beat.
  logic           fixed_q;
  button_report_t fixed_report_q;

  // Mirror of the block's registers and state.
  logic        lvl_q;
  logic [63:0] thr_lo_q;
  logic [63:0] thr_hi_q;
  logic [7:0]  cnt_q [LANES];
  logic [15:0] status_q;
  logic [15:0] prev_q;
  logic [15:0] flags_q;
  logic [15:0] disabled_q;

  button_report_t pending_reports [$];
  int errors;
  int checked_beats;
  int tick_beats;
  int read_hits;
  int settings_done;
  int send_run;
  logic send_calm;

  multi_channel_button_debouncer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .pin_levels_i  (pin_levels_i),
    .channel_i     (channel_i),
    .enable_i      (enable_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_bits_o (status_bits_o),
    .event_bits_o  (event_bits_o),
    .event_read_o  (event_read_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  // Debouncer state after reset.
  function automatic void debounce_reset();
    lvl_q      = 1'b0;
    thr_lo_q   = THR_RESET;
    thr_hi_q   = THR_RESET;
    status_q   = '0;
    prev_q     = '0;
    flags_q    = '0;
    disabled_q = '0;
    for (int i = 0; i < LANES; i++) cnt_q[i] = RELOAD_LOW;
  endfunction

  // Applies one beat to the mirrored state and returns the report it causes.
  function automatic button_report_t debounce_step(input button_beat_t b);
    button_report_t r;
    logic [15:0] pressed, rise, fall;
    logic [63:0] word;
    logic [7:0]  thr;
    r = '0;
    case (b.action)
      ACT_TICK: begin
        pressed = (lvl_q ? b.pins : ~b.pins) & ~disabled_q;
        for (int c = 0; c < LANES; c++) begin
          word = (c < 8) ? thr_lo_q : thr_hi_q;
          thr  = word[8*(c%8) +: 8];
          if (thr < THR_MIN) thr = THR_MIN;
          if (pressed[c]) begin
            cnt_q[c] = cnt_q[c] + 8'd1;
            if (cnt_q[c] >= thr) begin
              status_q[c] = 1'b1;
              cnt_q[c]    = RELOAD_HIGH;
            end
          end else begin
            cnt_q[c] = cnt_q[c] - 8'd1;
            if (cnt_q[c] == 8'd0) begin
              cnt_q[c]    = RELOAD_LOW;
              status_q[c] = 1'b0;
            end
          end
        end
        rise    = status_q & ~prev_q;
        fall    = prev_q & ~status_q;
        flags_q = (flags_q | rise) & ~fall;
        prev_q  = status_q;
      end
      ACT_ENABLE: begin
        if (b.en) begin
          disabled_q[b.chan] = 1'b0;
          cnt_q[b.chan]      = RELOAD_LOW;
        end else begin
          disabled_q[b.chan] = 1'b1;
          status_q[b.chan]   = 1'b0;
          flags_q[b.chan]    = 1'b0;
        end
      end
      default: ;
    endcase
    r.events = flags_q;
    if (b.action == ACT_READ) begin
      r.rd             = flags_q[b.chan];
      flags_q[b.chan]  = 1'b0;
    end
    r.status = status_q;
    return r;
  endfunction

  // Scoreboard: check output beats, then predict accepted input beats.
  always @(posedge clk_i) begin
    button_report_t got, want;
    button_beat_t   b;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = '{status_bits_o, event_bits_o, event_read_o};
        if (pending_reports.size() == 0) begin
          $display("%0t: output beat with nothing expected: status %h events %h read %b",
                   $time, got.status, got.events, got.rd);
          errors++;
        end else begin
          want = pending_reports.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status_bits expected %h actual %h", $time, want.status, got.status);
            errors++;
          end
          if (got.events !== want.events) begin
            $display("%0t: event_bits expected %h actual %h", $time, want.events, got.events);
            errors++;
          end
          if (got.rd !== want.rd) begin
            $display("%0t: event_read expected %b actual %b", $time, want.rd, got.rd);
            errors++;
          end
          checked_beats++;
          if (want.rd) read_hits++;
        end
      end
      if (in_valid_i && in_ready_o) begin
        b = '{action_i, pin_levels_i, channel_i, enable_i};
        want = debounce_step(b);
        if (fixed_q) want = fixed_report_q;
        pending_reports.push_back(want);
        if (b.action == ACT_TICK) tick_beats++;
      end
    end
  end

  // Receiver: random stalls per beat, calm stretches, and one long hold-off
  // that lets the block fill up and push back on its input.
  initial begin
    int gap;
    int taken;
    int run;
    logic calm;
    taken = 0;
    run   = 0;
    calm  = 1'b0;
    out_ready_i <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (run == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        run  = $urandom_range(20, 80);
      end
      run--;
      gap = calm ? 0 : $urandom_range(0, 6);
      if (taken == 300) gap = 80;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
    end
  end

  // Offers one input beat after a random gap and waits for it to be taken.
  task automatic send_beat(input button_beat_t b, input logic fixed,
                           input button_report_t fx);
    int gap;
    if (send_run == 0) begin
      send_calm = ($urandom_range(0, 3) == 0);
      send_run  = $urandom_range(20, 80);
    end
    send_run--;
    gap = send_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    action_i       <= b.action;
    pin_levels_i   <= b.pins;
    channel_i      <= b.chan;
    enable_i       <= b.en;
    fixed_q        <= fixed;
    fixed_report_q <= fx;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stops offering beats and waits until every report has come back. The
  // first edge lets the scoreboard record the last accepted beat.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_ACTIVE_LEVEL: lvl_q    = val[0];
      CFG_THR_LOW:      thr_lo_q = val;
      CFG_THR_HIGH:     thr_hi_q = val;
      default: ;
    endcase
  endtask

  // Main sequence: reset, directed steps, then random phases per setting.
  initial begin
    button_beat_t   b;
    button_report_t fx;
    logic [15:0]    held;
    logic [15:0]    bounce;
    int             pick;
    errors        = 0;
    checked_beats = 0;
    tick_beats    = 0;
    read_hits     = 0;
    settings_done = 0;
    send_run      = 0;
    send_calm     = 1'b0;
    held          = '1;
    debounce_reset();
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    action_i       <= ACT_TICK;
    pin_levels_i   <= '0;
    channel_i      <= '0;
    enable_i       <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= CFG_ACTIVE_LEVEL;
    cfg_data_i     <= '0;
    fixed_q        <= 1'b0;
    fixed_report_q <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed steps at the reset settings.
    for (int i = 0; i < NUM_ROWS; i++) begin
      b  = '{DIR_ROWS[i].action, DIR_ROWS[i].pins, DIR_ROWS[i].chan, DIR_ROWS[i].en};
      fx = '{DIR_ROWS[i].status, DIR_ROWS[i].events, DIR_ROWS[i].rd};
      send_beat(b, DIR_ROWS[i].fixed, fx);
    end
    drain();

    // Random phases: mostly held buttons with bounce, some noise and
    // occasional reads, enables, disables and unused actions.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(CFG_ACTIVE_LEVEL, {63'd0, PHASES[p].lvl});
      write_reg(CFG_THR_LOW, PHASES[p].lo);
      write_reg(CFG_THR_HIGH, PHASES[p].hi);
      settings_done++;
      for (int n = 0; n < PHASES[p].beats; n++) begin
        if ($urandom_range(1, PHASES[p].churn) == 1) held = 16'($urandom);
        else if ($urandom_range(0, 7) == 0) held[$urandom_range(0, 15)] ^= 1'b1;
        bounce = 16'($urandom & $urandom & $urandom);
        if (PHASES[p].churn > 100) bounce &= 16'($urandom);
        b.pins = ($urandom_range(0, 9) == 0) ? 16'($urandom) : (held ^ bounce);
        b.chan = 4'($urandom);
        b.en   = ($urandom_range(0, 3) != 0);
        pick   = $urandom_range(0, 99);
        if (pick < 80)      b.action = ACT_TICK;
        else if (pick < 88) b.action = ACT_READ;
        else if (pick < 96) b.action = ACT_ENABLE;
        else                b.action = ACT_UNUSED;
        send_beat(b, 1'b0, '0);
      end
      drain();
    end

    repeat (5) @(posedge clk_i);
    $display("tb: %0d beats checked, %0d ticks, %0d reads returned a set flag,",
             checked_beats, tick_beats, read_hits);
    $display("tb: over %0d register settings including low and full thresholds",
             settings_done + 1);
    if (errors == 0 && pending_reports.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/mcbd_pkg.sv
rtl/mcbd_lane.sv
rtl/mcbd_merge.sv
rtl/multi_channel_button_debouncer.sv
sim/tb.sv
